FILE: hdl/circular_list_manager_defines.svh
// Assertion macros used by the checker file clm_checker.sv.
// No dependencies.
`ifndef CIRCULAR_LIST_MANAGER_DEFINES_SVH
`define CIRCULAR_LIST_MANAGER_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define CLM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define CLM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/clm_pkg.sv
// Shared types and codes for the circular list manager.
// No dependencies.
package clm_pkg;

    localparam int unsigned POOL_NODES_DEF = 16;
    localparam int unsigned VALUE_BITS_DEF = 32;

    typedef enum logic [2:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_END   = 3'd1,
        CMD_INS_AFTER = 3'd2,
        CMD_REM_FRONT = 3'd3,
        CMD_REM_END   = 3'd4,
        CMD_REM_VALUE = 3'd5,
        CMD_DUMP      = 3'd6,
        CMD_NOP       = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] value;
        logic signed [31:0] key;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] item;
        logic               item_valid;
        logic               last;
    } rsp_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_READ,
        FSM_WALK,
        FSM_DONE
    } fsm_t;

endpackage

FILE: hdl/circular_list_manager.sv
// Circular list manager top level: node pool in two memories; depends on clm_pkg.
// Status-only answers and inserts into an empty list answer from FSM_DONE; other inserts
// go through FSM_READ and FSM_DONE, remove-front through FSM_READ into FSM_WALK;
// searches, remove-end and dump walk one node per cycle, up to element_count nodes.
// A new request is taken in the cycle after the last result, once busy is low;
// results cannot be stalled. Reset empties the list and frees every node.
module circular_list_manager
#(
    parameter int unsigned POOL_NODES = clm_pkg::POOL_NODES_DEF,
    parameter int unsigned VALUE_BITS = clm_pkg::VALUE_BITS_DEF
)(
    input  logic             clk,
    input  logic             rst_n,
    input  clm_pkg::req_t    req,
    input  logic             start,
    output logic             busy,
    output clm_pkg::rsp_t    rsp,
    output logic             rsp_strobe
);
    import clm_pkg::*;

    localparam int unsigned IW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
    localparam int unsigned CW = $clog2(POOL_NODES + 1);

    // node pool memories, synchronous read
    logic [VALUE_BITS-1:0] val_mem [POOL_NODES];
    logic [IW-1:0]         link_mem [POOL_NODES];

    logic [POOL_NODES-1:0] free_reg, free_next;
    logic [IW-1:0]         tail_reg, tail_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    fsm_t                  fsm_reg, fsm_next;
    cmd_t                  cmd_reg, cmd_next;
    status_t               st_reg, st_next;     // status of a single-result request
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [VALUE_BITS-1:0] key_reg, key_next;
    logic [IW-1:0]         cur_reg, cur_next;   // node being read
    logic [IW-1:0]         prev_reg, prev_next; // predecessor of cur
    logic [CW-1:0]         idx_reg, idx_next;   // walk step count

    // memory ports
    logic                  rd_en;
    logic [IW-1:0]         rd_addr;
    logic [VALUE_BITS-1:0] rd_val;
    logic [IW-1:0]         rd_link;
    logic                  wv_en, wl_en, wl2_en;
    logic [IW-1:0]         wv_addr, wl_addr, wl2_addr;
    logic [VALUE_BITS-1:0] wv_data;
    logic [IW-1:0]         wl_data, wl2_data;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_val  <= val_mem[rd_addr];
            rd_link <= link_mem[rd_addr];
        end
        if (wv_en)
            val_mem[wv_addr] <= wv_data;
        if (wl_en)
            link_mem[wl_addr] <= wl_data;
        if (wl2_en)
            link_mem[wl2_addr] <= wl2_data;
    end

    // lowest free node
    logic [IW-1:0] alloc_idx;
    logic          alloc_ok;
    always_comb
    begin
        alloc_idx = '0;
        alloc_ok  = 1'b0;
        for (int i = POOL_NODES - 1; i >= 0; i--)
        begin
            if (free_reg[i])
            begin
                alloc_idx = IW'(i);
                alloc_ok  = 1'b1;
            end
        end
    end

    function automatic logic [31:0] ext(input logic [VALUE_BITS-1:0] v);
        logic [63:0] w;
        w = 64'(signed'(v));
        return w[31:0];
    endfunction

    logic [VALUE_BITS-1:0] in_val, in_key;
    assign in_val = VALUE_BITS'(64'(signed'(req.value)));
    assign in_key = VALUE_BITS'(64'(signed'(req.key)));

    // walk conditions on the node just read (cur_reg)
    logic key_hit, rem_hit, walk_last;
    assign key_hit   = (rd_val == key_reg);
    assign rem_hit   = (cmd_reg == CMD_REM_FRONT) || (rd_val == val_reg);
    assign walk_last = ((idx_reg + CW'(1)) == cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg  <= FSM_IDLE;
            free_reg <= '1;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            fsm_reg  <= fsm_next;
            free_reg <= free_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        st_reg   <= st_next;
        val_reg  <= val_next;
        key_reg  <= key_next;
        cur_reg  <= cur_next;
        prev_reg <= prev_next;
        idx_reg  <= idx_next;
    end

    assign busy = (fsm_reg != FSM_IDLE);

    // next state and memory ports
    always_comb
    begin
        fsm_next  = fsm_reg;
        free_next = free_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        cmd_next  = cmd_reg;
        st_next   = st_reg;
        val_next  = val_reg;
        key_next  = key_reg;
        cur_next  = cur_reg;
        prev_next = prev_reg;
        idx_next  = idx_reg;
        rd_en = 1'b0; rd_addr = '0;
        wv_en = 1'b0; wv_addr = '0; wv_data = '0;
        wl_en = 1'b0; wl_addr = '0; wl_data = '0;
        wl2_en = 1'b0; wl2_addr = '0; wl2_data = '0;

        unique case (fsm_reg)
            FSM_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd_t'(req.command);
                    val_next = in_val;
                    key_next = in_key;
                    st_next  = ST_OK;
                    fsm_next = FSM_DONE;
                    unique case (cmd_t'(req.command))
                        CMD_INS_FRONT, CMD_INS_END:
                        begin
                            if (!alloc_ok)
                                st_next = ST_FULL;
                            else if (cnt_reg == '0)
                            begin
                                wv_en = 1'b1; wv_addr = alloc_idx; wv_data = in_val;
                                wl_en = 1'b1; wl_addr = alloc_idx; wl_data = alloc_idx;
                                free_next[alloc_idx] = 1'b0;
                                tail_next = alloc_idx;
                                cnt_next = cnt_reg + 1'b1;
                            end
                            else
                            begin
                                rd_en = 1'b1; rd_addr = tail_reg;
                                fsm_next = FSM_READ;
                            end
                        end
                        CMD_NOP:
                            st_next = ST_OK;
                        default:
                        begin
                            if (cnt_reg == '0)
                                st_next = ST_EMPTY;
                            else
                            begin
                                rd_en = 1'b1; rd_addr = tail_reg;
                                fsm_next = FSM_READ;
                            end
                        end
                    endcase
                end
            end
            FSM_READ:
            begin
                // rd_link is the head index; tail node data is in rd_val
                unique case (cmd_reg)
                    CMD_INS_FRONT, CMD_INS_END:
                    begin
                        wv_en = 1'b1; wv_addr = alloc_idx; wv_data = val_reg;
                        wl_en = 1'b1; wl_addr = alloc_idx; wl_data = rd_link;
                        wl2_en = 1'b1; wl2_addr = tail_reg; wl2_data = alloc_idx;
                        free_next[alloc_idx] = 1'b0;
                        if (cmd_reg == CMD_INS_END)
                            tail_next = alloc_idx;
                        cnt_next = cnt_reg + 1'b1;
                        fsm_next = FSM_DONE;
                    end
                    default:
                    begin
                        // start walk at head
                        prev_next = tail_reg;
                        cur_next  = rd_link;
                        idx_next  = '0;
                        rd_en = 1'b1; rd_addr = rd_link;
                        fsm_next = FSM_WALK;
                    end
                endcase
            end
            FSM_WALK:
            begin
                // rd_val/rd_link belong to cur_reg, idx_reg is its position
                rd_en = 1'b1; rd_addr = rd_link;
                prev_next = cur_reg;
                cur_next  = rd_link;
                idx_next  = idx_reg + 1'b1;
                unique case (cmd_reg)
                    CMD_INS_AFTER:
                    begin
                        if (key_hit)
                        begin
                            fsm_next = FSM_IDLE;
                            if (alloc_ok)
                            begin
                                wv_en = 1'b1; wv_addr = alloc_idx; wv_data = val_reg;
                                wl_en = 1'b1; wl_addr = alloc_idx; wl_data = rd_link;
                                wl2_en = 1'b1; wl2_addr = cur_reg; wl2_data = alloc_idx;
                                free_next[alloc_idx] = 1'b0;
                                if (cur_reg == tail_reg)
                                    tail_next = alloc_idx;
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        else if (walk_last)
                            fsm_next = FSM_IDLE;
                    end
                    CMD_REM_VALUE, CMD_REM_FRONT:
                    begin
                        if (rem_hit)
                        begin
                            fsm_next = FSM_IDLE;
                            free_next[cur_reg] = 1'b1;
                            cnt_next = cnt_reg - 1'b1;
                            if (cnt_reg == CW'(1))
                                tail_next = '0;
                            else
                            begin
                                wl_en = 1'b1; wl_addr = prev_reg; wl_data = rd_link;
                                if (cur_reg == tail_reg)
                                    tail_next = prev_reg;
                            end
                        end
                        else if (walk_last)
                            fsm_next = FSM_IDLE;
                    end
                    CMD_REM_END:
                    begin
                        if (walk_last)
                        begin
                            fsm_next = FSM_IDLE;
                            free_next[cur_reg] = 1'b1;
                            cnt_next = cnt_reg - 1'b1;
                            if (cnt_reg == CW'(1))
                                tail_next = '0;
                            else
                            begin
                                wl_en = 1'b1; wl_addr = prev_reg; wl_data = rd_link;
                                tail_next = prev_reg;
                            end
                        end
                    end
                    default:
                    begin
                        // dump
                        if (walk_last)
                            fsm_next = FSM_IDLE;
                    end
                endcase
            end
            default:
            begin
                // single result sent from st_reg
                fsm_next = FSM_IDLE;
            end
        endcase
    end

    // results
    always_comb
    begin
        rsp_strobe = 1'b0;
        rsp = '0;
        rsp.last = 1'b1;

        unique case (fsm_reg)
            FSM_DONE:
            begin
                rsp_strobe = 1'b1;
                rsp.status = st_reg;
            end
            FSM_WALK:
            begin
                unique case (cmd_reg)
                    CMD_INS_AFTER:
                    begin
                        if (key_hit)
                        begin
                            rsp_strobe = 1'b1;
                            rsp.status = alloc_ok ? ST_OK : ST_FULL;
                        end
                        else if (walk_last)
                        begin
                            rsp_strobe = 1'b1;
                            rsp.status = ST_NOT_FOUND;
                        end
                    end
                    CMD_REM_VALUE, CMD_REM_FRONT:
                    begin
                        if (rem_hit)
                        begin
                            rsp_strobe = 1'b1;
                            rsp.item = ext(rd_val);
                            rsp.item_valid = 1'b1;
                        end
                        else if (walk_last)
                        begin
                            rsp_strobe = 1'b1;
                            rsp.status = ST_NOT_FOUND;
                        end
                    end
                    CMD_REM_END:
                    begin
                        if (walk_last)
                        begin
                            rsp_strobe = 1'b1;
                            rsp.item = ext(rd_val);
                            rsp.item_valid = 1'b1;
                        end
                    end
                    default:
                    begin
                        // dump, one element per cycle
                        rsp_strobe = 1'b1;
                        rsp.item = ext(rd_val);
                        rsp.item_valid = 1'b1;
                        rsp.last = walk_last;
                    end
                endcase
            end
            default:
                rsp_strobe = 1'b0;
        endcase
    end

endmodule

FILE: hdl/clm_checker.sv
// Port-level checker for the circular list manager, bound to the top level.
// Depends on clm_pkg and circular_list_manager_defines.svh.
`include "circular_list_manager_defines.svh"
module clm_checker
(
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input clm_pkg::rsp_t rsp,
    input logic          rsp_strobe
);
    import clm_pkg::*;

    // an accepted request always makes the block busy on the next cycle
    `CLM_ASSERT_NEXT(a_accept, clk, rst_n, start && !busy, busy)
    // a result without a value carries no item
    `CLM_ASSERT_IMPL(a_zero, clk, rst_n, rsp_strobe && !rsp.item_valid, rsp.item == '0)
    // a final result frees the block
    `CLM_ASSERT_NEXT(a_free, clk, rst_n, rsp_strobe && rsp.last, !busy)
    // non-ok status has no item
    `CLM_ASSERT_IMPL(a_stat, clk, rst_n, rsp_strobe && rsp.status != ST_OK, !rsp.item_valid)
endmodule

bind circular_list_manager clm_checker u_clm_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .rsp(rsp), .rsp_strobe(rsp_strobe)
);

FILE: dv/circular_list_manager_test.sv
// Testbench for circular_list_manager: drives list commands, predicts every response
// with an in-bench list model and compares each strobed response field by field.
// Depends on clm_pkg and the circular_list_manager RTL.
`timescale 1ns / 100ps

module circular_list_manager_test;
    import clm_pkg::*;

    localparam int NODES = POOL_NODES_DEF;
    localparam int CYCLE_LIMIT = 400000;

    logic  clk;
    logic  rst_n;
    req_t  req;
    logic  start;
    logic  busy;
    rsp_t  rsp;
    logic  rsp_strobe;

    circular_list_manager u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .start      (start),
        .busy       (busy),
        .rsp        (rsp),
        .rsp_strobe (rsp_strobe)
    );

    // Shadow list: values kept head first; its size is the pool occupancy.
    // Node indexes never show on the ports, so an ordered queue is enough
    // to predict every response.
    logic [31:0] list_vals[$];
    rsp_t        pending_rsp[$];
    int          error_count;
    int          cycle_count;
    int          rsp_count;
    int          req_count;

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // Watchdog: one fail line and out.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic rsp_t mk_rsp(status_t st, logic [31:0] item, logic vld, logic lst);
        rsp_t r;
        r.status = st;
        r.item = item;
        r.item_valid = vld;
        r.last = lst;
        return r;
    endfunction

    // Apply one request to the shadow list and queue what should come back.
    task automatic predict_list_cmd(input req_t r);
        int pos;
        pos = -1;
        case (cmd_t'(r.command))
            CMD_INS_FRONT, CMD_INS_END:
            begin
                if (list_vals.size() >= NODES)
                    pending_rsp.push_back(mk_rsp(ST_FULL, 0, 0, 1));
                else
                begin
                    if (r.command == CMD_INS_FRONT)
                        list_vals.push_front(r.value);
                    else
                        list_vals.push_back(r.value);
                    pending_rsp.push_back(mk_rsp(ST_OK, 0, 0, 1));
                end
            end
            CMD_INS_AFTER:
            begin
                for (int i = 0; i < list_vals.size() && pos < 0; i++)
                    if (list_vals[i] == r.key)
                        pos = i;
                // Not-found wins over full, matching the search-first order.
                if (list_vals.size() == 0)
                    pending_rsp.push_back(mk_rsp(ST_EMPTY, 0, 0, 1));
                else if (pos < 0)
                    pending_rsp.push_back(mk_rsp(ST_NOT_FOUND, 0, 0, 1));
                else if (list_vals.size() >= NODES)
                    pending_rsp.push_back(mk_rsp(ST_FULL, 0, 0, 1));
                else
                begin
                    list_vals.insert(pos + 1, r.value);
                    pending_rsp.push_back(mk_rsp(ST_OK, 0, 0, 1));
                end
            end
            CMD_REM_FRONT, CMD_REM_END:
            begin
                if (list_vals.size() == 0)
                    pending_rsp.push_back(mk_rsp(ST_EMPTY, 0, 0, 1));
                else if (r.command == CMD_REM_FRONT)
                    pending_rsp.push_back(mk_rsp(ST_OK, list_vals.pop_front(), 1, 1));
                else
                    pending_rsp.push_back(mk_rsp(ST_OK, list_vals.pop_back(), 1, 1));
            end
            CMD_REM_VALUE:
            begin
                for (int i = 0; i < list_vals.size() && pos < 0; i++)
                    if (list_vals[i] == r.value)
                        pos = i;
                if (list_vals.size() == 0)
                    pending_rsp.push_back(mk_rsp(ST_EMPTY, 0, 0, 1));
                else if (pos < 0)
                    pending_rsp.push_back(mk_rsp(ST_NOT_FOUND, 0, 0, 1));
                else
                begin
                    pending_rsp.push_back(mk_rsp(ST_OK, list_vals[pos], 1, 1));
                    list_vals.delete(pos);
                end
            end
            CMD_DUMP:
            begin
                if (list_vals.size() == 0)
                    pending_rsp.push_back(mk_rsp(ST_EMPTY, 0, 0, 1));
                else
                    foreach (list_vals[i])
                        pending_rsp.push_back(mk_rsp(ST_OK, list_vals[i], 1,
                                                     i == list_vals.size() - 1));
            end
            default:
                pending_rsp.push_back(mk_rsp(ST_OK, 0, 0, 1));
        endcase
    endtask

    // Send one request: drive at the falling edge and hold it while busy is
    // high; the next rising edge with busy low takes it.
    task automatic send_request(input cmd_t cmd, input logic [31:0] val, input logic [31:0] k);
        req_t r;
        r.command = cmd;
        r.value = val;
        r.key = k;
        @(negedge clk);
        req <= r;
        start <= 1'b1;
        while (busy)
            @(negedge clk);
        @(posedge clk);
        predict_list_cmd(r);
        req_count++;
        @(negedge clk);
        start <= 1'b0;
    endtask

    // Random gap between bursts; bursts come from the caller's loop.
    task automatic sender_gap();
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 12)) @(negedge clk);
    endtask

    task automatic wait_drained();
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);
    endtask

    // Response checker: every strobe pops the oldest expectation.
    always @(posedge clk)
    begin
        rsp_t exp_r;
        if (rst_n && rsp_strobe)
        begin
            rsp_count++;
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: unexpected response, expected none, actual %p", $time, rsp);
                error_count++;
            end
            else
            begin
                exp_r = pending_rsp.pop_front();
                if (rsp.status !== exp_r.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                             rsp.status);
                    error_count++;
                end
                if (rsp.item !== exp_r.item)
                begin
                    $display("%0t: item expected %h actual %h", $time, exp_r.item, rsp.item);
                    error_count++;
                end
                if (rsp.item_valid !== exp_r.item_valid)
                begin
                    $display("%0t: item_valid expected %b actual %b", $time,
                             exp_r.item_valid, rsp.item_valid);
                    error_count++;
                end
                if (rsp.last !== exp_r.last)
                begin
                    $display("%0t: last expected %b actual %b", $time, exp_r.last, rsp.last);
                    error_count++;
                end
            end
        end
    end

    // Pick a value already on the list hit_pct percent of the time, so searches can hit.
    function automatic logic [31:0] pick_value(int hit_pct);
        if (list_vals.size() != 0 && $urandom_range(0, 99) < hit_pct)
            return list_vals[$urandom_range(0, list_vals.size() - 1)];
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'h8000_0000 ^ $urandom_range(0, 3);
            default: return $urandom_range(0, 15);
        endcase
    endfunction

    // Empty-list handling of the remove, insert-after and dump commands, plus NOP.
    task automatic test_empty_list();
        send_request(CMD_REM_FRONT, 0, 0);
        send_request(CMD_REM_END, 0, 0);
        send_request(CMD_REM_VALUE, 5, 0);
        send_request(CMD_INS_AFTER, 1, 2);
        send_request(CMD_DUMP, 0, 0);
        send_request(CMD_NOP, 32'hffff_ffff, 32'hffff_ffff);
    endtask

    // Extremes, insert-after at the tail, sole-node removal by value.
    task automatic test_directed_edges();
        send_request(CMD_INS_END, 32'h8000_0000, 0);
        send_request(CMD_REM_VALUE, 32'h8000_0000, 0);
        send_request(CMD_DUMP, 0, 0);
        send_request(CMD_INS_FRONT, 32'h7fff_ffff, 0);
        send_request(CMD_INS_AFTER, 32'hffff_ffff, 32'h7fff_ffff);
        send_request(CMD_INS_AFTER, 32'h0, 32'h1234);
        send_request(CMD_INS_FRONT, 32'h0, 0);
        send_request(CMD_DUMP, 0, 0);
        send_request(CMD_REM_END, 0, 0);
        send_request(CMD_REM_FRONT, 0, 0);
        send_request(CMD_REM_END, 0, 0);
        send_request(CMD_REM_END, 0, 0);
        wait_drained();
    endtask

    // Fill the pool, hit the full status, then not-found on a full pool.
    task automatic test_pool_full();
        for (int i = 0; i < NODES; i++)
            send_request(cmd_t'(i % 2), i * 3, 0);
        send_request(CMD_INS_END, 99, 0);
        send_request(CMD_INS_AFTER, 98, 3);
        send_request(CMD_INS_AFTER, 98, 32'h5555_5555);
        send_request(CMD_REM_VALUE, 32'h5555_5555, 0);
        send_request(CMD_DUMP, 0, 0);
        wait_drained();
        while (list_vals.size() != 0)
            send_request(CMD_REM_FRONT, 0, 0);
    endtask

    // Random mix of well-formed traffic with bursts and pauses.
    task automatic test_random_traffic(input int n_items);
        cmd_t c;
        for (int i = 0; i < n_items; i++)
        begin
            // Inserts favored, most strongly when the list is short.
            if ($urandom_range(0, 15) == 0)
                c = CMD_DUMP;
            else if ($urandom_range(0, 15) < 16 - list_vals.size() / 2)
                c = cmd_t'($urandom_range(0, 2));
            else
                c = cmd_t'($urandom_range(3, 7));
            send_request(c, pick_value(c == CMD_REM_VALUE ? 70 : 10), pick_value(75));
            sender_gap();
            if (i == n_items / 2)
                wait_drained();
        end
    endtask

    initial
    begin
        error_count = 0;
        cycle_count = 0;
        rsp_count = 0;
        req_count = 0;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_list();
        test_directed_edges();
        test_pool_full();
        test_random_traffic(305);
        wait_drained();

        $display("Sent %0d list requests, checked %0d responses incl. full/empty/missing.",
                 req_count, rsp_count);
        if (error_count == 0 && pending_rsp.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
